/* rtl/bsl1d_pkg.sv */
`default_nettype none

package bsl1d_pkg;

    // Configuration register indexes.
    localparam logic [0:0] REG_DIM_COUNT  = 1'b0;
    localparam logic [0:0] REG_DATA_COUNT = 1'b1;

    // Datapath operations issued by the controller.
    typedef logic [4:0] t_op;
    localparam t_op OP_NOP   = 5'd0;
    localparam t_op OP_ACCEPT = 5'd1;
    localparam t_op OP_DIFF  = 5'd2;
    localparam t_op OP_ACC   = 5'd3;
    localparam t_op OP_CLOSE = 5'd4;
    localparam t_op OP_LLOAD = 5'd5;
    localparam t_op OP_URD   = 5'd6;
    localparam t_op OP_UDIV  = 5'd7;
    localparam t_op OP_UWR   = 5'd8;
    localparam t_op OP_FT    = 5'd9;
    localparam t_op OP_QRD   = 5'd10;
    localparam t_op OP_QMUL  = 5'd11;
    localparam t_op OP_QADD  = 5'd12;
    localparam t_op OP_NUM   = 5'd13;
    localparam t_op OP_CDIV  = 5'd14;
    localparam t_op OP_CMUL  = 5'd15;
    localparam t_op OP_VDIV  = 5'd16;
    localparam t_op OP_VSQ   = 5'd17;
    localparam t_op OP_OUT   = 5'd18;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic func;
        logic done;
        logic last;
        logic cap;
        logic len_zero;
        logic sqrt_busy;
        logic div_busy;
        logic last_i;
        logic t_lt2;
        logic out_free;
    } t_sts;

    localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
    localparam logic [14:0] U_MAX   = 15'h7FFF;

endpackage

`default_nettype wire

/* rtl/batch_sampled_l1_depth_top.sv */
`default_nettype none

// Sampled L1 depth of one query point. Query coordinates (tuser = 0) are
// written first, one dimension per beat; each one clears the accumulated
// sums. Sample coordinates (tuser = 1) follow in dimension order, and tlast on
// the final coordinate of the last sample produces one result beat. Items are
// handled one at a time. Closing a non-duplicate sample runs the 32-step
// length square root and then, for each dimension, the 64-step radix-2
// divider that normalises each component. The final result sums the
// components over the dimensions, then runs two divisions and one square
// root. The result register lets a new item enter while the previous result
// beat waits to be taken.
module batch_sampled_l1_depth_top #(
    parameter int DIM_MAX    = 64,
    parameter int SAMPLE_MAX = 1024
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [0:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [15:0] i_s_tdata,  // [15:0] coord
    input  wire logic [0:0]  i_s_tuser,  // [0] func
    input  wire logic        i_s_tlast,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [31:0]      o_m_tdata,  // [15:0] depth, [26:16] valid_samples
    output logic [0:0]       o_m_tuser   // [0] degenerate
);

    bsl1d_pkg::t_cmd cmd;
    bsl1d_pkg::t_sts sts;
    logic [15:0]     depth;
    logic [10:0]     valid_samples;
    logic            degenerate;

    bsl1d_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_sts      (sts),
        .o_s_tready (o_s_tready),
        .o_cmd      (cmd)
    );

    bsl1d_dp #(
        .DIM_MAX    (DIM_MAX),
        .SAMPLE_MAX (SAMPLE_MAX)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_func          (i_s_tuser[0]),
        .i_coord         (i_s_tdata),
        .i_last          (i_s_tlast),
        .i_m_tready      (i_m_tready),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_m_tvalid      (o_m_tvalid),
        .o_depth         (depth),
        .o_valid_samples (valid_samples),
        .o_degenerate    (degenerate)
    );

    assign o_m_tdata = {5'd0, valid_samples, depth};
    assign o_m_tuser = degenerate;

endmodule

`default_nettype wire

/* rtl/bsl1d_div.sv */
`default_nettype none

module bsl1d_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_num,
    input  wire logic [63:0] i_den,
    output logic             o_busy,
    output logic [63:0]      o_quo
);

    logic [64:0] r_rem;
    logic [63:0] r_quo;
    logic [63:0] r_den;
    logic [6:0]  r_cnt;
    logic        r_busy;

    logic [64:0] rem_sh;
    logic [64:0] rem_sub;
    logic        ge;

    // One quotient bit per cycle, restoring form.
    assign rem_sh  = {r_rem[63:0], r_quo[63]};
    assign rem_sub = rem_sh - {1'b0, r_den};
    assign ge      = rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 7'd0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 7'd64;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 7'd1;
            if (r_cnt == 7'd1) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= 65'd0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= ge ? rem_sub : rem_sh;
            r_quo <= {r_quo[62:0], ge};
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo;

endmodule

`default_nettype wire

/* rtl/bsl1d_sqrt.sv */
`default_nettype none

module bsl1d_sqrt (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_x,
    output logic             o_busy,
    output logic [31:0]      o_root
);

    logic [63:0] r_x;
    logic [63:0] r_r;
    logic [63:0] r_b;
    logic [5:0]  r_cnt;
    logic        r_busy;

    logic [63:0] rb;

    // Two radicand bits per cycle, one root bit.
    assign rb = r_r + r_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 6'd0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 6'd32;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= i_x;
            r_r <= 64'd0;
            r_b <= 64'd1 << 62;
        end else if (r_busy) begin
            if (r_x >= rb) begin
                r_x <= r_x - rb;
                r_r <= (r_r >> 1) + r_b;
            end else begin
                r_r <= r_r >> 1;
            end
            r_b <= r_b >> 2;
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_r[31:0];

endmodule

`default_nettype wire

/* rtl/bsl1d_ctrl.sv */
`default_nettype none

module bsl1d_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_s_tvalid,
    input  wire bsl1d_pkg::t_sts i_sts,
    output logic                 o_s_tready,
    output bsl1d_pkg::t_cmd      o_cmd
);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_DISP = 5'd1;
    localparam logic [4:0] S_ACC  = 5'd2;
    localparam logic [4:0] S_CHK  = 5'd3;
    localparam logic [4:0] S_SQW  = 5'd4;
    localparam logic [4:0] S_URD  = 5'd5;
    localparam logic [4:0] S_UDIV = 5'd6;
    localparam logic [4:0] S_UW   = 5'd7;
    localparam logic [4:0] S_UWR  = 5'd8;
    localparam logic [4:0] S_END  = 5'd9;
    localparam logic [4:0] S_FT   = 5'd10;
    localparam logic [4:0] S_FCHK = 5'd11;
    localparam logic [4:0] S_QRD  = 5'd12;
    localparam logic [4:0] S_QMUL = 5'd13;
    localparam logic [4:0] S_QADD = 5'd14;
    localparam logic [4:0] S_NUM  = 5'd15;
    localparam logic [4:0] S_CDIV = 5'd16;
    localparam logic [4:0] S_CW   = 5'd17;
    localparam logic [4:0] S_CMUL = 5'd18;
    localparam logic [4:0] S_VDIV = 5'd19;
    localparam logic [4:0] S_VW   = 5'd20;
    localparam logic [4:0] S_VSQ  = 5'd21;
    localparam logic [4:0] S_SW   = 5'd22;
    localparam logic [4:0] S_OUT  = 5'd23;

    logic [4:0] r_state;
    logic [4:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd.op   = bsl1d_pkg::OP_NOP;
        o_s_tready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.op = bsl1d_pkg::OP_ACCEPT;
                    n_state  = S_DISP;
                end
            end
            S_DISP: begin
                if (i_sts.func) begin
                    o_cmd.op = bsl1d_pkg::OP_DIFF;
                    n_state  = S_ACC;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_ACC: begin
                o_cmd.op = bsl1d_pkg::OP_ACC;
                n_state  = i_sts.done ? S_CHK : S_IDLE;
            end
            S_CHK: begin
                o_cmd.op = bsl1d_pkg::OP_CLOSE;
                n_state  = (i_sts.cap && !i_sts.len_zero) ? S_SQW : S_END;
            end
            S_SQW: begin
                if (!i_sts.sqrt_busy) begin
                    o_cmd.op = bsl1d_pkg::OP_LLOAD;
                    n_state  = S_URD;
                end
            end
            S_URD: begin
                o_cmd.op = bsl1d_pkg::OP_URD;
                n_state  = S_UDIV;
            end
            S_UDIV: begin
                o_cmd.op = bsl1d_pkg::OP_UDIV;
                n_state  = S_UW;
            end
            S_UW: begin
                if (!i_sts.div_busy) begin
                    n_state = S_UWR;
                end
            end
            S_UWR: begin
                o_cmd.op = bsl1d_pkg::OP_UWR;
                n_state  = i_sts.last_i ? S_END : S_URD;
            end
            S_END: begin
                n_state = i_sts.last ? S_FT : S_IDLE;
            end
            S_FT: begin
                o_cmd.op = bsl1d_pkg::OP_FT;
                n_state  = S_FCHK;
            end
            S_FCHK: begin
                n_state = i_sts.t_lt2 ? S_OUT : S_QRD;
            end
            S_QRD: begin
                o_cmd.op = bsl1d_pkg::OP_QRD;
                n_state  = S_QMUL;
            end
            S_QMUL: begin
                o_cmd.op = bsl1d_pkg::OP_QMUL;
                n_state  = S_QADD;
            end
            S_QADD: begin
                o_cmd.op = bsl1d_pkg::OP_QADD;
                n_state  = i_sts.last_i ? S_NUM : S_QRD;
            end
            S_NUM: begin
                o_cmd.op = bsl1d_pkg::OP_NUM;
                n_state  = S_CDIV;
            end
            S_CDIV: begin
                o_cmd.op = bsl1d_pkg::OP_CDIV;
                n_state  = S_CW;
            end
            S_CW: begin
                if (!i_sts.div_busy) begin
                    n_state = S_CMUL;
                end
            end
            S_CMUL: begin
                o_cmd.op = bsl1d_pkg::OP_CMUL;
                n_state  = S_VDIV;
            end
            S_VDIV: begin
                o_cmd.op = bsl1d_pkg::OP_VDIV;
                n_state  = S_VW;
            end
            S_VW: begin
                if (!i_sts.div_busy) begin
                    n_state = S_VSQ;
                end
            end
            S_VSQ: begin
                o_cmd.op = bsl1d_pkg::OP_VSQ;
                n_state  = S_SW;
            end
            S_SW: begin
                if (!i_sts.sqrt_busy) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.op = bsl1d_pkg::OP_OUT;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/bsl1d_dp.sv */
`default_nettype none

module bsl1d_dp #(
    parameter int DIM_MAX    = 64,
    parameter int SAMPLE_MAX = 1024
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [0:0]         i_cfg_idx,
    input  wire logic [31:0]        i_cfg_data,
    input  wire logic               i_func,
    input  wire logic signed [15:0] i_coord,
    input  wire logic               i_last,
    input  wire logic               i_m_tready,
    input  wire bsl1d_pkg::t_cmd    i_cmd,
    output bsl1d_pkg::t_sts         o_sts,
    output logic                    o_m_tvalid,
    output logic [15:0]             o_depth,
    output logic [10:0]             o_valid_samples,
    output logic                    o_degenerate
);

    localparam int IW  = (DIM_MAX > 1) ? $clog2(DIM_MAX) : 1;
    localparam int DW  = $clog2(DIM_MAX + 1);
    localparam int CW  = $clog2(SAMPLE_MAX + 1);
    localparam int USW = $clog2(SAMPLE_MAX) + 17;

    // Configuration.
    logic [6:0]  r_dim_count;
    logic [31:0] r_data_count;

    // Per-item and per-sample state.
    logic [DW-1:0]   r_dim_index;
    logic [IW-1:0]   r_idx;
    logic            r_func;
    logic            r_done;
    logic            r_last;
    logic [15:0]     r_coord;
    logic [15:0]     r_qrd;
    logic [33:0]     r_sq;
    logic [38:0]     r_len;
    logic [CW-1:0]   r_total;
    logic [CW-1:0]   r_dup;
    logic [31:0]     r_l;
    logic [DW-1:0]   r_i;
    logic [16:0]     r_drd;
    logic [USW-1:0]  r_usrd;
    logic            r_usv;
    logic [DIM_MAX-1:0] r_valid;

    // Final computation.
    logic [CW-1:0]   r_t;
    logic [63:0]     r_q;
    logic [63:0]     r_psq;
    logic [63:0]     r_num;
    logic [2*CW-1:0] r_den;
    logic            r_neg;
    logic [62:0]     r_prod;

    logic            r_o_valid;
    logic [15:0]     r_depth;
    logic [10:0]     r_vs;
    logic            r_deg;

    logic [15:0]    mem_query [DIM_MAX];
    logic [16:0]    mem_diff  [DIM_MAX];
    logic [USW-1:0] mem_us    [DIM_MAX];

    bsl1d_pkg::t_op op;

    logic [31:0]   dc_ext;
    logic [DW-1:0] dims;
    logic [DW-1:0] idx_cur;
    logic [DW:0]   idx_nxt;
    logic          acc_done;
    logic          last_i;
    logic          clr_acc;

    logic signed [16:0] d;
    logic [16:0]   dmag;
    logic [33:0]   sq;
    logic          cap;
    logic          len_zero;

    logic [16:0]   umag;
    logic [14:0]   u_val;
    logic [USW-1:0] us_old;
    logic [USW-1:0] us_new;
    logic [USW-1:0] us_abs;
    logic [2*USW-1:0] psq_full;

    logic [63:0]   nabs;
    logic [31:0]   n_eff;
    logic [31:0]   nm1;
    logic [31:0]   nm2;
    logic [30:0]   cmag;
    logic [62:0]   prod;
    logic [63:0]   w;
    logic [63:0]   v;
    logic [15:0]   depth_calc;

    logic          div_start;
    logic [63:0]   div_num;
    logic [63:0]   div_den;
    logic          div_busy;
    logic [63:0]   div_quo;
    logic          sqrt_start;
    logic [63:0]   sqrt_x;
    logic          sqrt_busy;
    logic [31:0]   sqrt_root;

    logic          out_free;

    assign op = i_cmd.op;

    // Dimension count in effect: zero acts as one, large values saturate.
    assign dc_ext = {25'd0, r_dim_count};
    assign dims = (r_dim_count == 7'd0) ? DW'(1)
                : (dc_ext > 32'(DIM_MAX)) ? DW'(DIM_MAX) : DW'(dc_ext);
    assign idx_cur  = (r_dim_index >= dims) ? '0 : r_dim_index;
    assign idx_nxt  = {1'b0, idx_cur} + {{DW{1'b0}}, 1'b1};
    assign acc_done = idx_nxt >= {1'b0, dims};
    assign last_i   = ({1'b0, r_i} + {{DW{1'b0}}, 1'b1}) >= {1'b0, dims};

    assign d    = $signed({r_coord[15], r_coord}) - $signed({r_qrd[15], r_qrd});
    assign dmag = d[16] ? 17'(-d) : 17'(d);
    assign sq   = dmag * dmag;
    assign cap      = r_total < CW'(SAMPLE_MAX);
    assign len_zero = r_len == 39'd0;

    // Unit vector component: |d| * 2^27 / L rounded to nearest.
    assign umag   = r_drd[16] ? 17'(-r_drd) : r_drd;
    assign u_val  = (div_quo > {49'd0, bsl1d_pkg::U_MAX}) ? bsl1d_pkg::U_MAX : div_quo[14:0];
    assign us_old = r_usv ? r_usrd : '0;
    assign us_new = r_drd[16] ? us_old - USW'(u_val) : us_old + USW'(u_val);
    assign us_abs = us_old[USW-1] ? USW'(-us_old) : us_old;
    assign psq_full = us_abs * us_abs;

    assign nabs  = r_num[63] ? 64'(-r_num) : r_num;
    assign n_eff = (r_data_count < 32'd2) ? 32'd2 : r_data_count;
    assign nm1   = n_eff - 32'd1;
    assign nm2   = n_eff - 32'd2;
    assign cmag  = (div_quo > bsl1d_pkg::ONE_Q30) ? bsl1d_pkg::ONE_Q30[30:0] : div_quo[30:0];
    assign prod  = cmag * nm2;
    assign w = r_neg ? ((r_prod > bsl1d_pkg::ONE_Q30[62:0]) ? 64'd0
                        : bsl1d_pkg::ONE_Q30 - {1'b0, r_prod})
                     : bsl1d_pkg::ONE_Q30 + {1'b0, r_prod};
    assign v = (div_quo > bsl1d_pkg::ONE_Q30) ? bsl1d_pkg::ONE_Q30 : div_quo;
    assign depth_calc = (sqrt_root == 32'd0) ? 16'hFFFF : 16'(32'd65536 - sqrt_root);

    always_comb begin
        div_start = 1'b0;
        div_num   = 64'd0;
        div_den   = 64'd1;
        case (op)
            bsl1d_pkg::OP_UDIV: begin
                div_start = 1'b1;
                div_num   = {19'd0, umag, 28'd0} + {32'd0, r_l};
                div_den   = {31'd0, r_l, 1'b0};
            end
            bsl1d_pkg::OP_CDIV: begin
                div_start = 1'b1;
                div_num   = (nabs << 1) + 64'(r_den);
                div_den   = 64'(r_den) << 1;
            end
            bsl1d_pkg::OP_VDIV: begin
                div_start = 1'b1;
                div_num   = w;
                div_den   = {32'd0, nm1};
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    assign sqrt_start = (op == bsl1d_pkg::OP_VSQ)
                     || ((op == bsl1d_pkg::OP_CLOSE) && cap && !len_zero);
    assign sqrt_x = (op == bsl1d_pkg::OP_VSQ) ? (v << 2) : {1'b0, r_len, 24'd0};

    bsl1d_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_quo   (div_quo)
    );

    bsl1d_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_start),
        .i_x     (sqrt_x),
        .o_busy  (sqrt_busy),
        .o_root  (sqrt_root)
    );

    assign out_free = !r_o_valid || i_m_tready;
    assign clr_acc  = ((op == bsl1d_pkg::OP_ACCEPT) && !i_func) || (op == bsl1d_pkg::OP_OUT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim_count  <= 7'd1;
            r_data_count <= 32'd2;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bsl1d_pkg::REG_DIM_COUNT:  r_dim_count  <= i_cfg_data[6:0];
                bsl1d_pkg::REG_DATA_COUNT: r_data_count <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Control state and accumulators that reset clears.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim_index <= '0;
            r_len       <= 39'd0;
            r_total     <= '0;
            r_dup       <= '0;
            r_valid     <= '0;
            r_o_valid   <= 1'b0;
        end else begin
            if (op == bsl1d_pkg::OP_ACCEPT) begin
                r_dim_index <= acc_done ? '0 : idx_nxt[DW-1:0];
            end
            if (op == bsl1d_pkg::OP_ACC) begin
                r_len <= r_len + 39'(r_sq);
            end
            if (op == bsl1d_pkg::OP_CLOSE) begin
                r_len <= 39'd0;
                if (cap) begin
                    r_total <= r_total + CW'(1);
                    if (len_zero) begin
                        r_dup <= r_dup + CW'(1);
                    end
                end
            end
            if (op == bsl1d_pkg::OP_UWR) begin
                r_valid[r_i[IW-1:0]] <= 1'b1;
            end
            if (clr_acc) begin
                r_len   <= 39'd0;
                r_total <= '0;
                r_dup   <= '0;
                r_valid <= '0;
            end
            if (op == bsl1d_pkg::OP_OUT) begin
                r_o_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        case (op)
            bsl1d_pkg::OP_ACCEPT: begin
                r_coord <= i_coord;
                r_func  <= i_func;
                r_last  <= i_last;
                r_done  <= acc_done;
                r_idx   <= idx_cur[IW-1:0];
            end
            bsl1d_pkg::OP_DIFF:  r_sq <= sq;
            bsl1d_pkg::OP_LLOAD: begin
                r_l <= sqrt_root;
                r_i <= '0;
            end
            bsl1d_pkg::OP_UWR:   r_i <= r_i + DW'(1);
            bsl1d_pkg::OP_FT: begin
                r_t <= r_total - r_dup;
                r_q <= 64'd0;
                r_i <= '0;
            end
            bsl1d_pkg::OP_QMUL:  r_psq <= 64'(psq_full);
            bsl1d_pkg::OP_QADD: begin
                r_q <= r_q + r_psq;
                r_i <= r_i + DW'(1);
            end
            bsl1d_pkg::OP_NUM: begin
                r_num <= r_q - (64'(r_t) << 30);
                r_den <= (2*CW)'(r_t) * (2*CW)'(r_t - CW'(1));
            end
            bsl1d_pkg::OP_CDIV:  r_neg <= r_num[63];
            bsl1d_pkg::OP_CMUL:  r_prod <= prod;
            bsl1d_pkg::OP_OUT: begin
                r_depth <= (r_t < CW'(2)) ? 16'd0 : depth_calc;
                r_vs    <= 11'(r_t);
                r_deg   <= r_t < CW'(2);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (op == bsl1d_pkg::OP_ACCEPT) begin
            r_qrd <= mem_query[idx_cur[IW-1:0]];
            if (!i_func) begin
                mem_query[idx_cur[IW-1:0]] <= i_coord;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (op == bsl1d_pkg::OP_DIFF) begin
            mem_diff[r_idx] <= 17'(d);
        end
        if (op == bsl1d_pkg::OP_URD) begin
            r_drd <= mem_diff[r_i[IW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (op == bsl1d_pkg::OP_URD || op == bsl1d_pkg::OP_QRD) begin
            r_usrd <= mem_us[r_i[IW-1:0]];
            r_usv  <= r_valid[r_i[IW-1:0]];
        end
        if (op == bsl1d_pkg::OP_UWR) begin
            mem_us[r_i[IW-1:0]] <= us_new;
        end
    end

    assign o_sts.func      = r_func;
    assign o_sts.done      = r_done;
    assign o_sts.last      = r_last;
    assign o_sts.cap       = cap;
    assign o_sts.len_zero  = len_zero;
    assign o_sts.sqrt_busy = sqrt_busy;
    assign o_sts.div_busy  = div_busy;
    assign o_sts.last_i    = last_i;
    assign o_sts.t_lt2     = r_t < CW'(2);
    assign o_sts.out_free  = out_free;

    assign o_m_tvalid      = r_o_valid;
    assign o_depth         = r_depth;
    assign o_valid_samples = r_vs;
    assign o_degenerate    = r_deg;

    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");

    a_sqrt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sqrt_start |-> !sqrt_busy)
        else $error("root unit restarted while busy");

    a_dup_le_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dup <= r_total)
        else $error("duplicate count exceeds sample count");

    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (op == bsl1d_pkg::OP_OUT) |-> out_free)
        else $error("result overwrote a beat not yet taken");

    a_out_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (op == bsl1d_pkg::OP_OUT) |=> r_o_valid)
        else $error("result register not loaded");

endmodule

`default_nettype wire

/* verif/tb_batch_sampled_l1_depth_top.sv */
`default_nettype none

module tb_batch_sampled_l1_depth_top;

    localparam int DIMS_TOP   = 64;
    localparam int SAMPLE_TOP = 1024;
    // Longest idle stretch a sample can keep the block busy with no result.
    localparam int SETTLE_CYCLES = 6000;

    typedef struct {
        logic [15:0] depth;
        logic [10:0] count;
        logic        degen;
    } t_depth_res;

    typedef struct {
        logic        func;
        logic [15:0] coord;
        logic        last;
        logic        typed;
        logic [15:0] depth;
        logic [10:0] count;
        logic        degen;
    } t_stim_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [0:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [15:0] i_s_tdata;
    logic [0:0]  i_s_tuser;
    logic        i_s_tlast;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [31:0] o_m_tdata;
    logic [0:0]  o_m_tuser;

    batch_sampled_l1_depth_top #(
        .DIM_MAX    (DIMS_TOP),
        .SAMPLE_MAX (SAMPLE_TOP)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    // Shadow of the block's state.
    logic [6:0]         sh_dim_reg;
    logic [31:0]        sh_n_reg;
    logic signed [15:0] sh_query [DIMS_TOP];
    int                 sh_diff [DIMS_TOP];
    longint             sh_usum [DIMS_TOP];
    logic [38:0]        sh_len;
    int                 sh_idx;
    int                 sh_samples;
    int                 sh_dups;

    t_depth_res depth_q[$];
    int         err_cnt;
    int         send_idle;
    int         recv_stall;
    int         hold_reqs;
    int         hold_seen;
    int         hold_left;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #40000000;
        $display("end of test: mismatches");
        $finish;
    end

    function automatic logic [63:0] isqrt(input logic [63:0] x);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic int dims_eff();
        if (sh_dim_reg == 0) return 1;
        if (sh_dim_reg > DIMS_TOP) return DIMS_TOP;
        return int'(sh_dim_reg);
    endfunction

    task automatic clear_sums();
        for (int i = 0; i < DIMS_TOP; i++) sh_usum[i] = 0;
        sh_len = 0;
        sh_samples = 0;
        sh_dups = 0;
    endtask

    task automatic add_unit(input int dims);
        logic [63:0] len;
        logic [63:0] mag;
        logic [63:0] u;
        len = isqrt({25'd0, sh_len} << 24);
        if (len != 0) begin
            for (int i = 0; i < dims; i++) begin
                mag = (sh_diff[i] < 0) ? 64'(-sh_diff[i]) : 64'(sh_diff[i]);
                u = ((mag << 28) + len) / (len << 1);
                if (u > 64'd32767) u = 64'd32767;
                if (sh_diff[i] < 0) sh_usum[i] -= longint'(u);
                else sh_usum[i] += longint'(u);
            end
        end
    endtask

    function automatic t_depth_res depth_of_set(input int dims);
        t_depth_res res;
        int          t;
        longint      n;
        longint      q;
        longint      num;
        longint      den;
        longint      mag;
        longint      c;
        longint      w;
        logic [63:0] v;
        logic [63:0] r;
        t = sh_samples - sh_dups;
        n = (sh_n_reg < 2) ? 2 : longint'({32'd0, sh_n_reg});
        res.depth = 0;
        res.degen = 1'b1;
        res.count = t[10:0];
        if (t >= 2) begin
            q = 0;
            for (int i = 0; i < dims; i++) q += sh_usum[i] * sh_usum[i];
            num = q - longint'(t) * (64'sd1 <<< 30);
            den = longint'(t) * longint'(t - 1);
            mag = (num < 0) ? -num : num;
            mag = (2 * mag + den) / (2 * den);
            if (mag > (64'sd1 <<< 30)) mag = 64'sd1 <<< 30;
            c = (num < 0) ? -mag : mag;
            w = c * (n - 2) + (64'sd1 <<< 30);
            if (w < 0) w = 0;
            v = 64'(w / (n - 1));
            if (v > bsl1d_pkg::ONE_Q30) v = bsl1d_pkg::ONE_Q30;
            r = isqrt(v << 2);
            r = 64'd65536 - r;
            res.depth = (r > 64'd65535) ? 16'hFFFF : r[15:0];
            res.degen = 1'b0;
        end
        return res;
    endfunction

    // Advances the shadow state by one accepted beat; done is set when a set closes.
    task automatic predict_depth(input logic func, input logic [15:0] coord,
                                 input logic last, output bit done,
                                 output t_depth_res res);
        int  dims;
        int  idx;
        bit  closes;
        int  d;
        longint m;
        dims = dims_eff();
        done = 0;
        res = '{default: '0};
        if (sh_idx >= dims) sh_idx = 0;
        idx = sh_idx;
        sh_idx = idx + 1;
        closes = (sh_idx >= dims);
        if (closes) sh_idx = 0;
        if (!func) begin
            sh_query[idx] = $signed(coord);
            clear_sums();
        end else begin
            d = int'($signed(coord)) - int'(sh_query[idx]);
            sh_diff[idx] = d;
            m = (d < 0) ? -d : d;
            sh_len = sh_len + 39'(m * m);
            if (closes) begin
                if (sh_samples < SAMPLE_TOP) begin
                    sh_samples++;
                    if (sh_len == 0) sh_dups++;
                    else add_unit(dims);
                end
                sh_len = 0;
                if (last) begin
                    res = depth_of_set(dims);
                    clear_sums();
                    done = 1;
                end
            end
        end
    endtask

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        err_cnt++;
    endtask

    // Offers one beat and returns once it has been taken.
    task automatic send_beat(input logic func, input logic [15:0] coord, input logic last,
                             output bit done, output t_depth_res res);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle) begin
            i_s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tdata  = coord;
        i_s_tuser  = func;
        i_s_tlast  = last;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        predict_depth(func, coord, last, done, res);
    endtask

    task automatic send_checked(input logic func, input logic [15:0] coord, input logic last);
        bit         done;
        t_depth_res res;
        send_beat(func, coord, last, done, res);
        if (done) depth_q.push_back(res);
    endtask

    task automatic drain_idle();
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        while (depth_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [31:0] value);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == bsl1d_pkg::REG_DIM_COUNT) sh_dim_reg = value[6:0];
        else sh_n_reg = value;
    endtask

    task automatic run_phase(input logic [6:0] dim_reg, input logic [31:0] n_reg,
                             input int sets, input int max_samples,
                             input int idle, input int stall, input bit hold);
        int          dims;
        int          cnt;
        bit          dup;
        bit          wide;
        logic [15:0] c;
        logic        lst;
        drain_idle();
        write_reg(bsl1d_pkg::REG_DIM_COUNT, {25'd0, dim_reg});
        write_reg(bsl1d_pkg::REG_DATA_COUNT, n_reg);
        send_idle  = idle;
        recv_stall = stall;
        dims = dims_eff();
        for (int i = 0; i < dims; i++) send_checked(1'b0, 16'($urandom), 1'b0);
        // Hold the result side off while short sets keep arriving.
        if (hold) hold_reqs++;
        for (int s = 0; s < sets; s++) begin
            cnt = $urandom_range(max_samples, 1);
            for (int k = 0; k < cnt; k++) begin
                dup  = ($urandom_range(99) < 20);
                wide = ($urandom_range(99) < 25);
                for (int j = 0; j < dims; j++) begin
                    // Now and then a stray query beat lands in the middle of a sample.
                    if ($urandom_range(99) < 2)
                        send_checked(1'b0, 16'($urandom_range(20)) - 16'd10, 1'($urandom));
                    if (dup) c = sh_query[sh_idx < dims ? sh_idx : 0];
                    else if (wide) c = 16'($urandom);
                    else c = sh_query[sh_idx < dims ? sh_idx : 0] + 16'($urandom_range(6)) - 16'd3;
                    if (j == dims - 1) lst = (k == cnt - 1);
                    else lst = 1'($urandom);
                    send_checked(1'b1, c, lst);
                end
            end
        end
    endtask

    // Result side: random stalls, plus long hold-offs on request.
    always @(negedge i_clk) begin
        if (hold_reqs != hold_seen) begin
            hold_seen = hold_reqs;
            hold_left = 3000;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready = 1'b0;
        end else begin
            i_m_tready = ($urandom_range(99) >= recv_stall);
        end
    end

    always @(posedge i_clk) begin
        t_depth_res want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (depth_q.size() == 0) begin
                report("unexpected result beat", int'(o_m_tdata), 0);
            end else begin
                want = depth_q.pop_front();
                if (o_m_tdata[15:0] !== want.depth)
                    report("depth", int'(o_m_tdata[15:0]), int'(want.depth));
                if (o_m_tdata[26:16] !== want.count)
                    report("valid_samples", int'(o_m_tdata[26:16]), int'(want.count));
                if (o_m_tdata[31:27] !== 5'd0)
                    report("tdata padding", int'(o_m_tdata[31:27]), 0);
                if (o_m_tuser[0] !== want.degen)
                    report("degenerate", int'(o_m_tuser[0]), int'(want.degen));
            end
        end
    end

    t_stim_row rows[$];

    initial begin
        bit         done;
        t_depth_res res;
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tuser  = '0;
        i_s_tlast  = 1'b0;
        i_m_tready = 1'b0;
        err_cnt    = 0;
        send_idle  = 0;
        recv_stall = 0;
        hold_reqs  = 0;
        hold_seen  = 0;
        hold_left  = 0;
        sh_dim_reg = 7'd1;
        sh_n_reg   = 32'd2;
        sh_idx     = 0;
        for (int i = 0; i < DIMS_TOP; i++) begin
            sh_query[i] = 0;
            sh_diff[i] = 0;
        end
        clear_sums();

        // Reset values: one dimension, n of two.
        rows = '{
            '{1'b0, 16'h8000, 1'b0, 1'b0, 16'd0, 11'd0, 1'b0},
            // Largest difference, lone sample: degenerate.
            '{1'b1, 16'h7FFF, 1'b1, 1'b1, 16'd0, 11'd1, 1'b1},
            // Zero distance only: no valid sample left.
            '{1'b1, 16'h8000, 1'b1, 1'b1, 16'd0, 11'd0, 1'b1},
            '{1'b0, 16'h0000, 1'b0, 1'b0, 16'd0, 11'd0, 1'b0},
            '{1'b1, 16'h0000, 1'b0, 1'b0, 16'd0, 11'd0, 1'b0},
            '{1'b1, 16'h0005, 1'b0, 1'b0, 16'd0, 11'd0, 1'b0},
            '{1'b1, 16'hFFFB, 1'b1, 1'b0, 16'd0, 11'd0, 1'b0},
            '{1'b0, 16'h7FFF, 1'b1, 1'b0, 16'd0, 11'd0, 1'b0},
            '{1'b1, 16'h8000, 1'b0, 1'b0, 16'd0, 11'd0, 1'b0},
            '{1'b1, 16'h8000, 1'b1, 1'b0, 16'd0, 11'd0, 1'b0},
            '{1'b1, 16'h0001, 1'b0, 1'b0, 16'd0, 11'd0, 1'b0},
            '{1'b1, 16'h0001, 1'b0, 1'b0, 16'd0, 11'd0, 1'b0},
            '{1'b1, 16'h0002, 1'b1, 1'b0, 16'd0, 11'd0, 1'b0}
        };

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (rows[r]) begin
            send_beat(rows[r].func, rows[r].coord, rows[r].last, done, res);
            if (done) begin
                if (rows[r].typed) depth_q.push_back('{rows[r].depth, rows[r].count,
                                                       rows[r].degen});
                else depth_q.push_back(res);
            end
        end

        // Oversized dimension count, starting from dimension zero, so that every
        // query and difference entry holds a written value before stray query
        // beats can shift the alignment.
        drain_idle();
        write_reg(bsl1d_pkg::REG_DIM_COUNT, 32'd127);
        for (int i = 0; i < DIMS_TOP; i++) send_checked(1'b0, 16'($urandom), 1'b0);
        for (int i = 0; i < DIMS_TOP; i++)
            send_checked(1'b1, 16'($urandom), i == DIMS_TOP - 1);

        run_phase(7'd1, 32'd2, 20, 3, 0, 0, 1'b0);
        run_phase(7'd3, 32'hFFFF_FFFF, 10, 3, 57, 0, 1'b0);
        run_phase(7'd0, 32'd1, 10, 2, 0, 57, 1'b0);
        run_phase(7'd1, 32'd0, 30, 2, 0, 0, 1'b1);
        run_phase(7'd8, 32'd1000, 4, 3, 19, 19, 1'b0);
        run_phase(7'd64, 32'd100, 1, 1, 57, 57, 1'b0);
        run_phase(7'd2, 32'd7, 15, 3, 57, 57, 1'b0);

        drain_idle();
        if (err_cnt == 0 && depth_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

`default_nettype wire
